// ===== sv/log_domain_squared_error_accumulator_unit_macros.svh =====
// assertion macros for the log-domain squared-error accumulator
// used by the top level only, no other dependencies
`ifndef LOG_DOMAIN_SQUARED_ERROR_ACCUMULATOR_UNIT_MACROS_SVH
`define LOG_DOMAIN_SQUARED_ERROR_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define LDSEA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LDSEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ldsea_pkg.sv =====
// shared constants, command and status types of the accumulator
// no dependencies
package ldsea_pkg;

    localparam int LOG_FRAC_BITS = 24;
    localparam int COUNT_WIDTH   = 40;
    localparam int LOG2_FRAC     = 34;
    localparam int ITER_LAST     = LOG2_FRAC - 1;
    localparam int ITER_W        = $clog2(LOG2_FRAC);
    localparam int LN_SHIFT      = LOG2_FRAC - LOG_FRAC_BITS;

    localparam logic [63:0]  LN2_Q64 = 64'hB17217F7D1CF79AB;
    localparam logic [63:0]  LN_RND  = 64'd1 << (LN_SHIFT - 1);
    localparam logic [127:0] SQ_RND  = 128'd1 << (LOG_FRAC_BITS - 1);

    localparam logic [1:0] ET_HALF   = 2'd0;
    localparam logic [1:0] ET_SINGLE = 2'd1;

    localparam logic REG_ELEMENT_TYPE = 1'b0;

    typedef enum logic [1:0] {
        MK_SQX  = 2'd0,
        MK_LN   = 2'd1,
        MK_DIFF = 2'd2,
        MK_UINT = 2'd3
    } mul_kind_t;

    typedef struct packed {
        logic      accept;
        logic      reject;
        logic      log_load;
        logic      log_orig;
        logic      norm_shift;
        logic      norm_fin;
        logic      mul_start;
        mul_kind_t mul_kind;
        logic      iter_upd;
        logic      ln_store;
        logic      acc;
        logic      emit;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic mode_uint;
        logic b_fin;
        logic a_fin;
        logic norm_top;
        logic mul_done;
        logic mul_busy;
        logic iter_last;
        logic ln_orig;
        logic last;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/ldsea_mul.sv =====
// 64x64 multiply-add over four 32x32 partial products, one per cycle
// depends on ldsea_pkg
module ldsea_mul
    import ldsea_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  op_a,
    input  logic [63:0]  op_b,
    input  logic [127:0] addend,
    output logic [127:0] prod,
    output logic         busy,
    output logic         done
);

    logic [63:0]  a_reg, b_reg, pp_reg;
    logic [127:0] acc_reg;
    logic [2:0]   step_reg;
    logic [1:0]   sh_reg;
    logic         run_reg, done_reg;
    logic [31:0]  ah, bh;
    logic [63:0]  pp_c;
    logic [127:0] pp_sh;

    always_comb begin
        ah   = step_reg[0] ? a_reg[63:32] : a_reg[31:0];
        bh   = step_reg[1] ? b_reg[63:32] : b_reg[31:0];
        pp_c = ah * bh;
        case (sh_reg)
            2'd0:    pp_sh = {64'd0, pp_reg};
            2'd3:    pp_sh = {pp_reg, 64'd0};
            default: pp_sh = {32'd0, pp_reg, 32'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= run_reg && (step_reg == 3'd4);
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end else if (run_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd4) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= addend;
        end else if (run_reg) begin
            if (step_reg != 3'd4) begin
                pp_reg <= pp_c;
                sh_reg <= step_reg[1:0];
            end
            if (step_reg != 3'd0) begin
                acc_reg <= acc_reg + pp_sh;
            end
        end
    end

    assign prod = acc_reg;
    assign busy = run_reg;
    assign done = done_reg;

endmodule

// ===== sv/ldsea_dp.sv =====
// datapath: operand registers, log2 normalize and squaring, totals, result register
// depends on ldsea_pkg and ldsea_mul
module ldsea_dp
    import ldsea_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [1:0]  element_type,
    input  logic [31:0] s_orig_bits,
    input  logic [31:0] s_reread_bits,
    input  logic        s_clear_before,
    input  logic        s_last_in_channel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_sum_squares,
    output logic [39:0] m_pixel_count,
    output logic        m_channel_rejected
);

    logic [31:0] a_reg, b_reg;
    logic        last_reg;
    logic [63:0] sum_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic        skip_reg;

    logic [63:0] x_reg;
    logic [5:0]  p_reg;
    logic [7:0]  s_reg;
    logic        neg_reg;
    logic        orig_reg;
    logic [LOG2_FRAC-1:0] frac_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic [63:0] va_reg, vb_reg;

    logic        m_valid_reg, m_rej_reg;
    logic [63:0] m_sum_reg;
    logic [39:0] m_cnt_reg;

    logic        mode_uint, out_free;
    logic [31:0] op_bits;
    logic [4:0]  he;
    logic [9:0]  hf;
    logic [7:0]  se;
    logic [22:0] sf;
    logic [63:0] hm, sm, n_c;
    logic [7:0]  s_c;
    logic        neg_c;

    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_add, prod;
    logic         mul_busy, mul_done;

    logic [63:0] x2, x_next, mag, d, ad, sq;
    logic [8:0]  ps;
    logic [31:0] ud;
    logic [64:0] sum_add;
    logic        sq_sat;

    assign mode_uint = (element_type != ET_HALF) && (element_type != ET_SINGLE);
    assign out_free  = !m_valid_reg || m_ready;

    // operand to integer n and extra exponent s, log taken of n * 2^s
    always_comb begin
        op_bits = cmd.log_orig ? a_reg : b_reg;
        he      = op_bits[14:10];
        hf      = op_bits[9:0];
        se      = op_bits[30:23];
        sf      = op_bits[22:0];
        hm      = 64'({1'b1, hf}) << (he - 5'd1);
        sm      = 64'({1'b1, sf}) << (se - 8'd1);
        s_c     = '0;
        if (element_type == ET_HALF) begin
            n_c   = ((he == 5'd0) ? 64'(hf) : hm) + 64'd1;
            neg_c = op_bits[15];
        end else begin
            neg_c = op_bits[31];
            if (se == 8'd0) begin
                n_c = 64'(sf) + 64'd1;
            end else if (se <= 8'd40) begin
                n_c = sm + 64'd1;
            end else begin
                n_c = 64'({1'b1, sf});
                s_c = se - 8'd1;
            end
        end
    end

    always_comb begin
        x2      = prod[125:62];
        x_next  = x2[63] ? {1'b0, x2[63:1]} : x2;
        ps      = 9'(p_reg) + 9'(s_reg);
        mag     = (prod[127:64] + LN_RND) >> LN_SHIFT;
        d       = va_reg - vb_reg;
        ad      = d[63] ? (64'd0 - d) : d;
        ud      = (a_reg > b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);
        sq_sat  = (prod >> (64 + LOG_FRAC_BITS)) != 128'd0;
        if (mode_uint) begin
            sq = prod[63:0];
        end else if (sq_sat) begin
            sq = '1;
        end else begin
            sq = prod[LOG_FRAC_BITS +: 64];
        end
        sum_add = 65'(sum_reg) + 65'(sq);
    end

    always_comb begin
        mul_add = '0;
        case (cmd.mul_kind)
            MK_SQX: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            MK_LN: begin
                mul_a = 64'({ps, frac_reg});
                mul_b = LN2_Q64;
            end
            MK_DIFF: begin
                mul_a   = ad;
                mul_b   = ad;
                mul_add = SQ_RND;
            end
            default: begin
                mul_a = 64'(ud);
                mul_b = 64'(ud);
            end
        endcase
    end

    ldsea_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .addend  (mul_add),
        .prod    (prod),
        .busy    (mul_busy),
        .done    (mul_done)
    );

    // totals and skip flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            skip_reg  <= 1'b0;
        end else begin
            if (cmd.accept && s_clear_before) begin
                sum_reg   <= '0;
                count_reg <= '0;
                skip_reg  <= 1'b0;
            end
            if (cmd.reject) begin
                sum_reg   <= '0;
                count_reg <= '0;
                skip_reg  <= 1'b1;
            end
            if (cmd.acc) begin
                sum_reg <= sum_add[64] ? '1 : sum_add[63:0];
                if (count_reg != '1) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.emit) begin
                skip_reg <= 1'b0;
            end
        end
    end

    // item and log working registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            a_reg    <= s_orig_bits;
            b_reg    <= s_reread_bits;
            last_reg <= s_last_in_channel;
        end
        if (cmd.log_load) begin
            x_reg    <= n_c;
            p_reg    <= 6'd63;
            s_reg    <= s_c;
            neg_reg  <= neg_c;
            orig_reg <= cmd.log_orig;
        end
        if (cmd.norm_shift) begin
            x_reg <= {x_reg[62:0], 1'b0};
            p_reg <= p_reg - 6'd1;
        end
        if (cmd.norm_fin) begin
            x_reg    <= {1'b0, x_reg[63:1]};
            frac_reg <= '0;
            iter_reg <= '0;
        end
        if (cmd.iter_upd) begin
            x_reg    <= x_next;
            frac_reg <= {frac_reg[LOG2_FRAC-2:0], x2[63]};
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.ln_store) begin
            if (orig_reg) begin
                va_reg <= neg_reg ? (64'd0 - mag) : mag;
            end else begin
                vb_reg <= neg_reg ? (64'd0 - mag) : mag;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_sum_reg <= sum_reg;
            m_cnt_reg <= 40'(count_reg);
            m_rej_reg <= skip_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_sum_squares      = m_sum_reg;
    assign m_pixel_count      = m_cnt_reg;
    assign m_channel_rejected = m_rej_reg;

    always_comb begin
        sts.skip      = skip_reg;
        sts.mode_uint = mode_uint;
        sts.b_fin     = (element_type == ET_HALF) ? (b_reg[14:10] != 5'h1f)
                                                  : (b_reg[30:23] != 8'hff);
        sts.a_fin     = (element_type == ET_HALF) ? (a_reg[14:10] != 5'h1f)
                                                  : (a_reg[30:23] != 8'hff);
        sts.norm_top  = x_reg[63];
        sts.mul_done  = mul_done;
        sts.mul_busy  = mul_busy;
        sts.iter_last = (iter_reg == ITER_W'(ITER_LAST));
        sts.ln_orig   = orig_reg;
        sts.last      = last_reg;
        sts.out_free  = out_free;
    end

endmodule

// ===== sv/ldsea_ctrl.sv =====
// controller state machine sequencing one request through the datapath
// depends on ldsea_pkg
module ldsea_ctrl
    import ldsea_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_CHECK    = 10'b0000000010,
        ST_NORM     = 10'b0000000100,
        ST_SQX_GO   = 10'b0000001000,
        ST_SQX_WAIT = 10'b0000010000,
        ST_LN_GO    = 10'b0000100000,
        ST_LN_WAIT  = 10'b0001000000,
        ST_DIFF_GO  = 10'b0010000000,
        ST_SQ_WAIT  = 10'b0100000000,
        ST_FIN      = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_kind = MK_SQX;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.skip) begin
                    state_next = ST_FIN;
                end else if (sts.mode_uint) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_kind  = MK_UINT;
                    state_next    = ST_SQ_WAIT;
                end else if (!sts.b_fin) begin
                    cmd.reject = 1'b1;
                    state_next = ST_FIN;
                end else if (!sts.a_fin) begin
                    state_next = ST_FIN;
                end else begin
                    // re-read value first, original second
                    cmd.log_load = 1'b1;
                    state_next   = ST_NORM;
                end
            end
            ST_NORM: begin
                if (sts.norm_top) begin
                    cmd.norm_fin = 1'b1;
                    state_next   = ST_SQX_GO;
                end else begin
                    cmd.norm_shift = 1'b1;
                end
            end
            ST_SQX_GO: begin
                cmd.mul_start = 1'b1;
                cmd.mul_kind  = MK_SQX;
                state_next    = ST_SQX_WAIT;
            end
            ST_SQX_WAIT: begin
                if (sts.mul_done) begin
                    cmd.iter_upd = 1'b1;
                    state_next   = sts.iter_last ? ST_LN_GO : ST_SQX_GO;
                end
            end
            ST_LN_GO: begin
                cmd.mul_start = 1'b1;
                cmd.mul_kind  = MK_LN;
                state_next    = ST_LN_WAIT;
            end
            ST_LN_WAIT: begin
                if (sts.mul_done) begin
                    cmd.ln_store = 1'b1;
                    if (sts.ln_orig) begin
                        state_next = ST_DIFF_GO;
                    end else begin
                        cmd.log_load = 1'b1;
                        cmd.log_orig = 1'b1;
                        state_next   = ST_NORM;
                    end
                end
            end
            ST_DIFF_GO: begin
                cmd.mul_start = 1'b1;
                cmd.mul_kind  = MK_DIFF;
                state_next    = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (sts.mul_done) begin
                    cmd.acc    = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!sts.last) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/log_domain_squared_error_accumulator_unit.sv =====
// Log-domain squared-error accumulator. One pixel request is taken at a time. In unsigned mode
// a request takes one multiply of the difference. In the float modes each of the two values
// is normalized one bit a cycle and then goes through 34 squaring steps plus one ln2 scaling
// on a shared 64x64 multiplier. That multiplier is built from one 32x32 multiplier that forms
// and adds four partial products in turn. The 34-step log2 loop on that multiplier sets the
// rate. A finished result waits in its own register so the next request is taken meanwhile.
// element_type lives at byte address 0.
// depends on ldsea_pkg, ldsea_ctrl, ldsea_dp and the macros header
module log_domain_squared_error_accumulator_unit
    import ldsea_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_orig_bits,
    input  logic [31:0] s_reread_bits,
    input  logic        s_clear_before,
    input  logic        s_last_in_channel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_sum_squares,
    output logic [39:0] m_pixel_count,
    output logic        m_channel_rejected,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t       cmd;
    sts_t       sts;
    logic [1:0] et_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            et_reg <= ET_HALF;
        end else if (psel && penable && pwrite && (paddr[2] == REG_ELEMENT_TYPE)) begin
            et_reg <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ELEMENT_TYPE) ? 32'(et_reg) : 32'd0;

    ldsea_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ldsea_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .element_type       (et_reg),
        .s_orig_bits        (s_orig_bits),
        .s_reread_bits      (s_reread_bits),
        .s_clear_before     (s_clear_before),
        .s_last_in_channel  (s_last_in_channel),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_sum_squares      (m_sum_squares),
        .m_pixel_count      (m_pixel_count),
        .m_channel_rejected (m_channel_rejected)
    );

`include "log_domain_squared_error_accumulator_unit_macros.svh"

    `LDSEA_ASSERT_NOW(a_emit_free, aclk, aresetn, cmd.emit, !m_valid || m_ready, "result overwritten")
    `LDSEA_ASSERT_NOW(a_mul_idle, aclk, aresetn, cmd.mul_start, !sts.mul_busy, "multiplier restarted")
    `LDSEA_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "request overlap")

endmodule
